### sv/aer_pkg.sv
package aer_pkg;

  // header window geometry
  localparam int WinLen = 42;
  localparam int CntW   = 6;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [WinLen-1:0][7:0] win_t;

  // protocol constants
  localparam logic [7:0] EthTypeHi    = 8'h08;
  localparam logic [7:0] EthTypeArpLo = 8'h06;
  localparam logic [7:0] EthTypeIpLo  = 8'h00;
  localparam logic [7:0] IpProtoIcmp  = 8'h01;
  localparam logic [7:0] ArpOpReply   = 8'h02;
  localparam logic [7:0] IcmpCkAdd    = 8'h08;
  localparam logic [7:0] IcmpCkWrap   = 8'hF8;

  localparam logic [47:0] OwnMacReset = 48'h2E095A9D0000;

  // queue between capture and emit sides
  localparam int QueueDepth = 2;

  typedef struct packed {
    logic       is_hdr;   // header window release, else pass-through byte
    logic [7:0] data;
    logic       last;
  } q_entry_t;

endpackage

### sv/aer_queue.sv
module aer_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  aer_pkg::q_entry_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output aer_pkg::q_entry_t pop_data_o
);

  localparam int PtrW = $clog2(aer_pkg::QueueDepth);

  aer_pkg::q_entry_t mem_q [aer_pkg::QueueDepth];
  logic [PtrW-1:0]   wptr_q, wptr_d;
  logic [PtrW-1:0]   rptr_q, rptr_d;
  logic [PtrW:0]     fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != (PtrW+1)'(aer_pkg::QueueDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(aer_pkg::QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(aer_pkg::QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

### sv/aer_front.sv
module aer_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [47:0]       own_mac_i,
  input  logic              frame_valid_i,
  output logic              frame_ready_o,
  input  logic [7:0]        frame_byte_i,
  input  logic              frame_end_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output aer_pkg::q_entry_t push_data_o,
  input  logic              hdr_taken_i,
  output aer_pkg::win_t     hdr_bytes_o,
  output aer_pkg::cnt_t     hdr_n_o
);

  aer_pkg::win_t win_q;
  aer_pkg::cnt_t count_q, count_d;
  aer_pkg::cnt_t hdr_n_q;
  logic [19:0]   sum_q, sum_d;
  logic          busy_q, busy_d;
  logic          full, last_win, acc, hdr_push;

  aer_pkg::win_t wz;
  logic          is_arp, is_icmp;
  logic [16:0]   fold1;
  logic [15:0]   fold2, cksum;

  assign full     = (count_q == aer_pkg::cnt_t'(aer_pkg::WinLen));
  assign last_win = (count_q == aer_pkg::cnt_t'(aer_pkg::WinLen - 1));

  // window bytes wait while the previous window is still unloaded
  assign frame_ready_o = push_ready_i & ~(busy_q & ~full);
  assign acc           = frame_valid_i & frame_ready_o;
  assign hdr_push      = acc & ~full & (last_win | frame_end_i);

  assign push_valid_o       = acc & (full | last_win | frame_end_i);
  assign push_data_o.is_hdr = ~full;
  assign push_data_o.data   = frame_byte_i;
  assign push_data_o.last   = frame_end_i;

  // frame position and running ip header sum
  always_comb begin
    count_d = count_q;
    sum_d   = (count_q == '0) ? '0 : sum_q;
    if (acc) begin
      if (frame_end_i) begin
        count_d = '0;
      end else if (!full) begin
        count_d = count_q + 1'b1;
      end
      if ((count_q inside {[14:33]}) && !(count_q inside {24, 25})) begin
        if (count_q[0]) begin
          sum_d = sum_d + {12'd0, frame_byte_i};
        end else begin
          sum_d = sum_d + {4'd0, frame_byte_i, 8'd0};
        end
      end
    end else begin
      sum_d = sum_q;
    end
  end

  // window held until the emit side loads it
  always_comb begin
    busy_d = busy_q;
    if (hdr_push) begin
      busy_d = 1'b1;
    end else if (hdr_taken_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      busy_q  <= 1'b0;
      hdr_n_q <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      busy_q  <= busy_d;
      if (hdr_push) begin
        hdr_n_q <= count_q + 1'b1;
      end
    end
  end

  // window capture
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < aer_pkg::WinLen; k++) begin
      if (acc && !full && count_q == aer_pkg::cnt_t'(k)) begin
        win_q[k] <= frame_byte_i;
      end
    end
  end

  // bytes past the frame end read as zero
  always_comb begin
    for (int k = 0; k < aer_pkg::WinLen; k++) begin
      wz[k] = (aer_pkg::cnt_t'(k) < hdr_n_q) ? win_q[k] : 8'd0;
    end
  end

  assign is_arp  = (wz[12] == aer_pkg::EthTypeHi) && (wz[13] == aer_pkg::EthTypeArpLo);
  assign is_icmp = (wz[12] == aer_pkg::EthTypeHi) && (wz[13] == aer_pkg::EthTypeIpLo) &&
                   (wz[23] == aer_pkg::IpProtoIcmp);

  // ones' complement fold of the header sum
  assign fold1 = {1'b0, sum_q[15:0]} + {13'd0, sum_q[19:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
  assign cksum = ~fold2;

  // reply rewrite
  always_comb begin
    hdr_bytes_o = wz;
    if (is_arp) begin
      for (int k = 0; k < 6; k++) begin
        hdr_bytes_o[k]      = wz[6+k];
        hdr_bytes_o[6+k]    = own_mac_i[47-8*k -: 8];
        hdr_bytes_o[22+k]   = own_mac_i[47-8*k -: 8];
        hdr_bytes_o[32+k]   = wz[22+k];
      end
      for (int k = 0; k < 4; k++) begin
        hdr_bytes_o[28+k] = wz[38+k];
        hdr_bytes_o[38+k] = wz[28+k];
      end
      hdr_bytes_o[21] = aer_pkg::ArpOpReply;
    end else if (is_icmp) begin
      for (int k = 0; k < 6; k++) begin
        hdr_bytes_o[k]   = wz[6+k];
        hdr_bytes_o[6+k] = wz[k];
      end
      for (int k = 0; k < 4; k++) begin
        hdr_bytes_o[26+k] = wz[30+k];
        hdr_bytes_o[30+k] = wz[26+k];
      end
      hdr_bytes_o[24] = cksum[15:8];
      hdr_bytes_o[25] = cksum[7:0];
      hdr_bytes_o[34] = 8'd0;
      hdr_bytes_o[36] = wz[36] + aer_pkg::IcmpCkAdd;
      hdr_bytes_o[37] = wz[37] + {7'd0, (wz[36] >= aer_pkg::IcmpCkWrap)};
    end
  end

  assign hdr_n_o = hdr_n_q;

endmodule

### sv/aer_back.sv
module aer_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  aer_pkg::q_entry_t pop_data_i,
  input  aer_pkg::win_t     hdr_bytes_i,
  input  aer_pkg::cnt_t     hdr_n_i,
  output logic              hdr_taken_o,
  output logic              reply_valid_o,
  input  logic              reply_ready_i,
  output logic [7:0]        reply_byte_o,
  output logic              reply_end_o
);

  aer_pkg::win_t sh_q;
  aer_pkg::cnt_t rem_q, rem_d;
  logic          end_q;
  logic          out_acc, pop;

  assign reply_valid_o = (rem_q != '0);
  assign reply_byte_o  = sh_q[0];
  assign reply_end_o   = end_q & (rem_q == aer_pkg::cnt_t'(1));
  assign out_acc       = reply_valid_o & reply_ready_i;

  // next transaction loads as the last pending byte leaves
  assign pop_ready_o = (rem_q == '0) | ((rem_q == aer_pkg::cnt_t'(1)) & reply_ready_i);
  assign pop         = pop_valid_i & pop_ready_o;
  assign hdr_taken_o = pop & pop_data_i.is_hdr;

  // bytes left to send
  always_comb begin
    rem_d = rem_q;
    if (pop) begin
      rem_d = pop_data_i.is_hdr ? hdr_n_i : aer_pkg::cnt_t'(1);
    end else if (out_acc) begin
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      end_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      if (pop) begin
        end_q <= pop_data_i.last;
      end
    end
  end

  // output shift line, byte 0 is on the port
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (pop_data_i.is_hdr) begin
        sh_q <= hdr_bytes_i;
      end else begin
        sh_q[0] <= pop_data_i.data;
      end
    end else if (out_acc) begin
      for (int k = 0; k < aer_pkg::WinLen - 1; k++) begin
        sh_q[k] <= sh_q[k+1];
      end
    end
  end

endmodule

### sv/arp_icmp_echo_rewriter_top.sv
// ARP / ICMP echo reply rewriter.
// frame channel (frame_valid_i/frame_ready_o) takes one received byte per
// transaction, destination MAC first, frame_end_i on the last byte.
// reply channel (reply_valid_o/reply_ready_i) gives the reply frame, one byte
// per transaction, reply_end_o on the byte answering the frame's last byte.
// the first 42 bytes (or the whole frame if shorter) are captured, rewritten
// as an ARP reply or ICMP echo reply (other windows unchanged) and sent from
// a 42-byte shift line, loaded once the window entry has passed the queue.
// later bytes of a long frame pass through the queue and the shift line at
// one byte per cycle unless the reply side stalls. the next frame's window
// bytes are held off until the emit side has loaded the previous window,
// which the 2-entry queue decouples.
// cfg_we_i/cfg_wdata_i write the station MAC used in ARP replies.
// reset empties the queue and the shift line and restores the default MAC.
// when the receiver stalls, the queue fills and frame_ready_o drops.
module arp_icmp_echo_rewriter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [47:0] cfg_wdata_i,
  input  logic        frame_valid_i,
  output logic        frame_ready_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_end_i,
  output logic        reply_valid_o,
  input  logic        reply_ready_i,
  output logic [7:0]  reply_byte_o,
  output logic        reply_end_o
);

  logic [47:0]       own_mac_q;
  logic              push_valid, push_ready, pop_valid, pop_ready, hdr_taken;
  aer_pkg::q_entry_t push_data, pop_data;
  aer_pkg::win_t     hdr_bytes;
  aer_pkg::cnt_t     hdr_n;

  // station MAC register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= aer_pkg::OwnMacReset;
    end else if (cfg_we_i) begin
      own_mac_q <= cfg_wdata_i;
    end
  end

  aer_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .own_mac_i     (own_mac_q),
    .frame_valid_i (frame_valid_i),
    .frame_ready_o (frame_ready_o),
    .frame_byte_i  (frame_byte_i),
    .frame_end_i   (frame_end_i),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data),
    .hdr_taken_i   (hdr_taken),
    .hdr_bytes_o   (hdr_bytes),
    .hdr_n_o       (hdr_n)
  );

  aer_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  aer_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_data_i    (pop_data),
    .hdr_bytes_i   (hdr_bytes),
    .hdr_n_i       (hdr_n),
    .hdr_taken_o   (hdr_taken),
    .reply_valid_o (reply_valid_o),
    .reply_ready_i (reply_ready_i),
    .reply_byte_o  (reply_byte_o),
    .reply_end_o   (reply_end_o)
  );

endmodule
